/* rtl/banked_memory_mapper_with_guards_macros.svh */
// Assertion helpers for the RTL that checks itself.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef BANKED_MEMORY_MAPPER_WITH_GUARDS_MACROS_SVH
`define BANKED_MEMORY_MAPPER_WITH_GUARDS_MACROS_SVH

// Same-cycle implication
`define BMMG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BMMG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bmmg_pkg.sv */
package bmmg_pkg;

    // Access kinds carried on the input tuser
    typedef enum logic [1:0]
    {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_FETCH = 2'd2,
        FUNC_XLATE = 2'd3
    } func_t;

    // Access targets carried on the output tuser
    typedef enum logic [1:0]
    {
        TGT_FLASH   = 2'd0,
        TGT_RAM     = 2'd1,
        TGT_IGNORED = 2'd2,
        TGT_BLOCKED = 2'd3
    } target_t;

    // Register indexes (byte address is 8 times the index)
    localparam logic [2:0] REG_BANK_PAGES   = 3'd0;
    localparam logic [2:0] REG_TOP_WIN      = 3'd1;
    localparam logic [2:0] REG_BOTTOM_WIN   = 3'd2;
    localparam logic [2:0] REG_FLASH_BOUNDS = 3'd3;
    localparam logic [2:0] REG_RAM_MASK     = 3'd4;
    localparam logic [2:0] REG_RAM_BOUNDS   = 3'd5;
    localparam logic [2:0] REG_WAIT_STATES  = 3'd6;
    localparam logic [2:0] REG_UNLOCKED     = 3'd7;

    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    // Wait-state byte slots
    localparam int WS_FLASH_WR   = 0;
    localparam int WS_RAM_WR     = 1;
    localparam int WS_FLASH_RD   = 2;
    localparam int WS_RAM_RD     = 3;
    localparam int WS_FLASH_EXEC = 4;
    localparam int WS_RAM_EXEC   = 5;

    // Pages and physical address limits
    localparam logic [8:0]  PAGE_TOP_WIN    = 9'h100;
    localparam logic [8:0]  PAGE_BOTTOM_WIN = 9'h101;
    localparam logic [8:0]  PAGE_PROTECTED  = 9'h0FE;
    localparam logic [22:0] PA_RAM_BASE     = 23'h400000;
    localparam logic [22:0] PA_RAM_END      = 23'h420000;
    localparam logic [22:0] PA_SEQ_LO_A     = 23'h3B0000;
    localparam logic [22:0] PA_SEQ_HI_A     = 23'h3C0000;
    localparam logic [22:0] PA_SEQ_LO_B     = 23'h3F0000;
    localparam logic [15:0] LA_OS_ENTRY     = 16'h0038;
    localparam logic [16:0] LA_UPPER_BASE   = 17'h08000;
    localparam logic [7:0]  BYTE_ERASED     = 8'hFF;

    localparam logic [2:0] PROT_LAST  = 3'd6;
    localparam logic [2:0] PROT_FULL  = 3'd7;
    localparam logic [2:0] PROT_CLEAR = 3'd0;

    typedef struct packed
    {
        logic [8:0] hi;
        logic [8:0] lo;
    } flash_bounds_t;

    typedef struct packed
    {
        logic [22:0] hi;
        logic [22:0] lo;
    } ram_bounds_t;

    // Configuration seen by the translation logic
    typedef struct packed
    {
        logic [3:0][8:0] bank_pages;
        logic [7:0]      top_window_size;
        logic [7:0]      bottom_window_size;
        flash_bounds_t   flash_exec_bounds;
        logic [22:0]     ram_exec_mask;
        ram_bounds_t     ram_exec_bounds;
        logic [5:0][7:0] wait_states;
        logic            flash_unlocked;
    } cfg_t;

    // One result word
    typedef struct packed
    {
        logic [2:0]  protect_level;
        logic        no_os_fault;
        logic        ram_exec_fault;
        logic        flash_exec_fault;
        logic [7:0]  wait_cycles;
        logic [7:0]  data_out;
        target_t     target;
        logic [22:0] phys_addr;
    } res_t;

    // Expected byte at each step of the unlock read sequence
    function automatic logic [7:0] unlock_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h00;
            3'd1:    b = 8'h00;
            3'd2:    b = 8'hED;
            3'd3:    b = 8'h56;
            3'd4:    b = 8'hF3;
            3'd5:    b = 8'hD3;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/banked_memory_mapper_with_guards.sv */
// Channel   Dir  Handshake          Word contents
// s_*       in   s_tvalid/s_tready  tuser: func; tdata: logical_addr, mem_data, write_data
// m_*       out  m_tvalid/m_tready  tuser: target; tdata: phys_addr .. protect_level
// apb       in   psel/penable       8 registers at 8*index, always ready
//
// One word per cycle sustained while m_tready stays high.
// The input register feeds a single translation stage that writes the result register.
// The unlock sequence state updates as each word moves into the result register.
// A stalled result register holds the input register too; s_tready drops only then.
// rst_n clears valid flags, sequence state and configuration registers.
`include "banked_memory_mapper_with_guards_macros.svh"

module banked_memory_mapper_with_guards
(
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // logical_addr, mem_data, write_data
    input  logic [1:0]                        s_tuser,  // func
    // master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // phys_addr, data_out, wait_cycles, flash_exec_fault, ram_exec_fault,
    // no_os_fault, protect_level, zero pad
    output logic [47:0]                       m_tdata,
    output logic [1:0]                        m_tuser,  // target
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bmmg_pkg::APB_AW-1:0]       paddr,
    input  logic [bmmg_pkg::APB_DW-1:0]       pwdata,
    output logic [bmmg_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    bmmg_pkg::cfg_t  cfg;
    logic            in_valid_reg;
    bmmg_pkg::func_t func_reg;
    logic [15:0]     addr_reg;
    logic [7:0]      mem_reg;
    logic [7:0]      wdata_reg;
    logic            out_valid_reg;
    bmmg_pkg::res_t  res_reg;
    bmmg_pkg::res_t  res_next;
    logic [2:0]      prot_state_reg;
    logic [2:0]      prot_state_next;
    logic            advance;
    logic            in_take;

    bmmg_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Flow control: result register frees up or is empty
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg  <= bmmg_pkg::func_t'(s_tuser);
            addr_reg  <= s_tdata[15:0];
            mem_reg   <= s_tdata[23:16];
            wdata_reg <= s_tdata[31:24];
        end
    end

    bmmg_xlate u_xlate
    (
        .cfg          (cfg),
        .func         (func_reg),
        .logical_addr (addr_reg),
        .mem_data     (mem_reg),
        .write_data   (wdata_reg),
        .prot_state   (prot_state_reg),
        .res          (res_next),
        .prot_next    (prot_state_next)
    );

    // Result register and sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            prot_state_reg <= bmmg_pkg::PROT_CLEAR;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
                prot_state_reg <= prot_state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            res_reg <= res_next;
    end

    // Output packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.target;
    assign m_tdata  = {3'b0,
                       res_reg.protect_level,
                       res_reg.no_os_fault,
                       res_reg.ram_exec_fault,
                       res_reg.flash_exec_fault,
                       res_reg.wait_cycles,
                       res_reg.data_out,
                       res_reg.phys_addr};

    // Checks
    `BMMG_ASSERT_NEXT(a_prot_hold, !(in_valid_reg && advance),
        prot_state_reg == $past(prot_state_reg), "sequence state moved without a word")
    `BMMG_ASSERT_SAME(a_prot_match, out_valid_reg,
        res_reg.protect_level == prot_state_reg, "reported level differs from state")
    `BMMG_ASSERT_SAME(a_blocked_quiet, out_valid_reg && (res_reg.target == bmmg_pkg::TGT_BLOCKED),
        (res_reg.data_out == bmmg_pkg::BYTE_ERASED) && (res_reg.wait_cycles == 8'd0)
        && !res_reg.flash_exec_fault && !res_reg.ram_exec_fault && !res_reg.no_os_fault,
        "blocked read carries data or faults")
    `BMMG_ASSERT_SAME(a_no_os_flag, out_valid_reg && res_reg.no_os_fault,
        res_reg.flash_exec_fault, "missing OS without flash exec fault")
    `BMMG_ASSERT_SAME(a_faults_excl, out_valid_reg,
        !(res_reg.ram_exec_fault && res_reg.flash_exec_fault && !res_reg.no_os_fault),
        "both exec faults from one access")

endmodule

/* rtl/bmmg_regs.sv */
module bmmg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bmmg_pkg::APB_AW-1:0]      paddr,
    input  logic [bmmg_pkg::APB_DW-1:0]      pwdata,
    output logic [bmmg_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    output bmmg_pkg::cfg_t                   cfg
);

    bmmg_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                bmmg_pkg::REG_BANK_PAGES:   cfg_reg.bank_pages <= pwdata[35:0];
                bmmg_pkg::REG_TOP_WIN:      cfg_reg.top_window_size <= pwdata[7:0];
                bmmg_pkg::REG_BOTTOM_WIN:   cfg_reg.bottom_window_size <= pwdata[7:0];
                bmmg_pkg::REG_FLASH_BOUNDS: cfg_reg.flash_exec_bounds <= pwdata[17:0];
                bmmg_pkg::REG_RAM_MASK:     cfg_reg.ram_exec_mask <= pwdata[22:0];
                bmmg_pkg::REG_RAM_BOUNDS:   cfg_reg.ram_exec_bounds <= pwdata[45:0];
                bmmg_pkg::REG_WAIT_STATES:  cfg_reg.wait_states <= pwdata[47:0];
                bmmg_pkg::REG_UNLOCKED:     cfg_reg.flash_unlocked <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            bmmg_pkg::REG_BANK_PAGES:   prdata[35:0] = cfg_reg.bank_pages;
            bmmg_pkg::REG_TOP_WIN:      prdata[7:0]  = cfg_reg.top_window_size;
            bmmg_pkg::REG_BOTTOM_WIN:   prdata[7:0]  = cfg_reg.bottom_window_size;
            bmmg_pkg::REG_FLASH_BOUNDS: prdata[17:0] = cfg_reg.flash_exec_bounds;
            bmmg_pkg::REG_RAM_MASK:     prdata[22:0] = cfg_reg.ram_exec_mask;
            bmmg_pkg::REG_RAM_BOUNDS:   prdata[45:0] = cfg_reg.ram_exec_bounds;
            bmmg_pkg::REG_WAIT_STATES:  prdata[47:0] = cfg_reg.wait_states;
            bmmg_pkg::REG_UNLOCKED:     prdata[0]    = cfg_reg.flash_unlocked;
            default: ;
        endcase
    end

endmodule

/* rtl/bmmg_xlate.sv */
module bmmg_xlate
(
    input  bmmg_pkg::cfg_t  cfg,
    input  bmmg_pkg::func_t func,
    input  logic [15:0]     logical_addr,
    input  logic [7:0]      mem_data,
    input  logic [7:0]      write_data,
    input  logic [2:0]      prot_state,
    output bmmg_pkg::res_t  res,
    output logic [2:0]      prot_next
);

    logic [8:0]  bank_page;
    logic [8:0]  page;
    logic [16:0] top_sum;
    logic [16:0] bottom_limit;
    logic        top_hit;
    logic        bottom_hit;
    logic [22:0] pa;
    logic        is_flash;
    logic        blocked;
    logic [22:0] ram_masked;
    logic        in_seq_range;
    logic [2:0]  track_next;
    logic        track;

    // Page selection: bank register, then the two upper-half windows
    assign bank_page    = cfg.bank_pages[logical_addr[15:14]];
    assign top_sum      = {1'b0, logical_addr} + {3'b0, cfg.top_window_size, 6'b0};
    assign top_hit      = top_sum[16];
    assign bottom_limit = bmmg_pkg::LA_UPPER_BASE + {3'b0, cfg.bottom_window_size, 6'b0};
    assign bottom_hit   = ({1'b0, logical_addr} < bottom_limit);

    always_comb
    begin
        page = bank_page;
        if (logical_addr[15])
        begin
            priority if (top_hit)
                page = bmmg_pkg::PAGE_TOP_WIN;
            else if (bottom_hit)
                page = bmmg_pkg::PAGE_BOTTOM_WIN;
            else
                page = bank_page;
        end
    end

    assign pa         = {page, logical_addr[13:0]};
    assign is_flash   = (pa < bmmg_pkg::PA_RAM_BASE);
    assign blocked    = (page == bmmg_pkg::PAGE_PROTECTED) && !cfg.flash_unlocked;
    assign ram_masked = pa & cfg.ram_exec_mask;

    // Unlock sequence tracker
    assign in_seq_range = ((pa >= bmmg_pkg::PA_SEQ_LO_A) && (pa < bmmg_pkg::PA_SEQ_HI_A))
                       || ((pa >= bmmg_pkg::PA_SEQ_LO_B) && (pa < bmmg_pkg::PA_RAM_BASE));

    always_comb
    begin
        priority if (!in_seq_range)
            track_next = bmmg_pkg::PROT_CLEAR;
        else if (prot_state == bmmg_pkg::PROT_LAST)
            track_next = bmmg_pkg::PROT_FULL;
        else if ((prot_state < bmmg_pkg::PROT_LAST)
                 && (mem_data == bmmg_pkg::unlock_byte(prot_state)))
            track_next = prot_state + 3'd1;
        else
            track_next = bmmg_pkg::PROT_CLEAR;
    end

    // Per-access result
    always_comb
    begin
        res                  = '0;
        res.phys_addr        = pa;
        res.target           = is_flash ? bmmg_pkg::TGT_FLASH : bmmg_pkg::TGT_RAM;
        track                = 1'b0;
        unique case (func)
            bmmg_pkg::FUNC_WRITE:
            begin
                res.data_out = write_data;
                priority if (is_flash)
                    res.wait_cycles = cfg.wait_states[bmmg_pkg::WS_FLASH_WR];
                else if (pa < bmmg_pkg::PA_RAM_END)
                    res.wait_cycles = cfg.wait_states[bmmg_pkg::WS_RAM_WR];
                else
                    res.target = bmmg_pkg::TGT_IGNORED;
            end
            bmmg_pkg::FUNC_READ,
            bmmg_pkg::FUNC_FETCH:
            begin
                if (blocked)
                begin
                    res.target   = bmmg_pkg::TGT_BLOCKED;
                    res.data_out = bmmg_pkg::BYTE_ERASED;
                end
                else
                begin
                    track        = 1'b1;
                    res.data_out = mem_data;
                    if (func == bmmg_pkg::FUNC_READ)
                    begin
                        res.wait_cycles = is_flash
                                        ? cfg.wait_states[bmmg_pkg::WS_FLASH_RD]
                                        : cfg.wait_states[bmmg_pkg::WS_RAM_RD];
                    end
                    else
                    begin
                        if (is_flash)
                        begin
                            res.wait_cycles      = cfg.wait_states[bmmg_pkg::WS_FLASH_EXEC];
                            res.flash_exec_fault = (page >= cfg.flash_exec_bounds.lo)
                                                && (page <= cfg.flash_exec_bounds.hi);
                        end
                        else
                        begin
                            res.wait_cycles    = cfg.wait_states[bmmg_pkg::WS_RAM_EXEC];
                            res.ram_exec_fault = (ram_masked < cfg.ram_exec_bounds.lo)
                                              || (ram_masked > cfg.ram_exec_bounds.hi);
                        end
                        // missing OS: erased byte at the restart vector
                        if ((mem_data == bmmg_pkg::BYTE_ERASED)
                            && (logical_addr == bmmg_pkg::LA_OS_ENTRY))
                        begin
                            res.no_os_fault      = 1'b1;
                            res.flash_exec_fault = 1'b1;
                        end
                    end
                end
            end
            bmmg_pkg::FUNC_XLATE: ;
            default: ;
        endcase
        prot_next         = track ? track_next : prot_state;
        res.protect_level = prot_next;
    end

endmodule

/* bench/tb_banked_memory_mapper_with_guards.sv */
`timescale 1ns / 100ps

module tb_banked_memory_mapper_with_guards;

    // One CPU access as the sender drives it
    typedef struct packed
    {
        bmmg_pkg::func_t func;
        logic [15:0]     addr;
        logic [7:0]      mem_byte;
        logic [7:0]      wr_byte;
    } access_t;

    // Receiver pacing modes
    typedef enum int
    {
        PACE_FULL,
        PACE_COIN,
        PACE_CYCLE,
        PACE_RARE
    } pace_t;

    localparam int HOLD_CYCLES = 300;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [31:0]                 s_tdata = '0;
    logic [1:0]                  s_tuser = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [47:0]                 m_tdata;
    logic [1:0]                  m_tuser;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [bmmg_pkg::APB_AW-1:0] paddr = '0;
    logic [bmmg_pkg::APB_DW-1:0] pwdata = '0;
    logic [bmmg_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    // Shadow of the mapper registers and unlock tracker
    bmmg_pkg::cfg_t mapper_cfg = '0;
    logic [2:0]     unlock_step = bmmg_pkg::PROT_CLEAR;
    logic [7:0]     unlock_key [6] = '{8'h00, 8'h00, 8'hED, 8'h56, 8'hF3, 8'hD3};

    access_t        accesses_to_send [$];
    bmmg_pkg::res_t translations_due [$];
    access_t        on_bus;

    int    mismatches = 0;
    int    burst_left = 0;
    int    gap_left = 0;
    int    gap_max = 0;
    pace_t pace = PACE_FULL;
    int    stall_tick = 0;
    int    hold_left = 0;
    int    hold_asks = 0;
    int    holds_served = 0;

    banked_memory_mapper_with_guards DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Bank page lookup with the upper-half windows on top
    function automatic logic [8:0] page_of(logic [15:0] addr);
        logic [8:0] page;
        page = mapper_cfg.bank_pages[addr[15:14]];
        if (addr[15])
        begin
            if (int'(addr) + 64 * int'(mapper_cfg.top_window_size) > 'hFFFF)
                page = bmmg_pkg::PAGE_TOP_WIN;
            else if (int'(addr) < 'h8000 + 64 * int'(mapper_cfg.bottom_window_size))
                page = bmmg_pkg::PAGE_BOTTOM_WIN;
        end
        return page;
    endfunction

    function automatic bit in_unlock_window(logic [22:0] pa);
        return pa >= bmmg_pkg::PA_SEQ_LO_A && pa < bmmg_pkg::PA_RAM_BASE
            && !(pa >= bmmg_pkg::PA_SEQ_HI_A && pa < bmmg_pkg::PA_SEQ_LO_B);
    endfunction

    // Unlock sequence: read/fetch bytes walk the key inside the window
    function automatic void advance_unlock(logic [22:0] pa, logic [7:0] value);
        if (!in_unlock_window(pa))
            unlock_step = bmmg_pkg::PROT_CLEAR;
        else if (unlock_step == bmmg_pkg::PROT_LAST)
            unlock_step = bmmg_pkg::PROT_FULL;
        else if (unlock_step < bmmg_pkg::PROT_LAST && value == unlock_key[unlock_step])
            unlock_step = unlock_step + 3'd1;
        else
            unlock_step = bmmg_pkg::PROT_CLEAR;
    endfunction

    // Result word for one access; updates the unlock tracker
    function automatic bmmg_pkg::res_t translate_access(access_t acc);
        logic [8:0]     page;
        logic [22:0]    pa;
        logic [22:0]    masked;
        bit             in_flash;
        bmmg_pkg::res_t r;
        page = page_of(acc.addr);
        pa = {page, acc.addr[13:0]};
        in_flash = pa < bmmg_pkg::PA_RAM_BASE;
        r = '0;
        r.phys_addr = pa;
        r.target = in_flash ? bmmg_pkg::TGT_FLASH : bmmg_pkg::TGT_RAM;
        case (acc.func)
            bmmg_pkg::FUNC_WRITE:
            begin
                r.data_out = acc.wr_byte;
                if (in_flash)
                    r.wait_cycles = mapper_cfg.wait_states[bmmg_pkg::WS_FLASH_WR];
                else if (pa < bmmg_pkg::PA_RAM_END)
                    r.wait_cycles = mapper_cfg.wait_states[bmmg_pkg::WS_RAM_WR];
                else
                    r.target = bmmg_pkg::TGT_IGNORED;
            end
            bmmg_pkg::FUNC_READ, bmmg_pkg::FUNC_FETCH:
            begin
                if (page == bmmg_pkg::PAGE_PROTECTED && !mapper_cfg.flash_unlocked)
                begin
                    r.target = bmmg_pkg::TGT_BLOCKED;
                    r.data_out = bmmg_pkg::BYTE_ERASED;
                end
                else
                begin
                    r.data_out = acc.mem_byte;
                    if (acc.func == bmmg_pkg::FUNC_READ)
                    begin
                        r.wait_cycles = in_flash
                                      ? mapper_cfg.wait_states[bmmg_pkg::WS_FLASH_RD]
                                      : mapper_cfg.wait_states[bmmg_pkg::WS_RAM_RD];
                    end
                    else if (in_flash)
                    begin
                        r.wait_cycles = mapper_cfg.wait_states[bmmg_pkg::WS_FLASH_EXEC];
                        r.flash_exec_fault = page >= mapper_cfg.flash_exec_bounds.lo
                                          && page <= mapper_cfg.flash_exec_bounds.hi;
                    end
                    else
                    begin
                        masked = pa & mapper_cfg.ram_exec_mask;
                        r.wait_cycles = mapper_cfg.wait_states[bmmg_pkg::WS_RAM_EXEC];
                        r.ram_exec_fault = masked < mapper_cfg.ram_exec_bounds.lo
                                        || masked > mapper_cfg.ram_exec_bounds.hi;
                    end
                    advance_unlock(pa, acc.mem_byte);
                    // missing OS: erased byte at the reset entry
                    if (acc.func == bmmg_pkg::FUNC_FETCH
                        && acc.mem_byte == bmmg_pkg::BYTE_ERASED
                        && acc.addr == bmmg_pkg::LA_OS_ENTRY)
                    begin
                        r.no_os_fault = 1'b1;
                        r.flash_exec_fault = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.protect_level = unlock_step;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Compare one result word with the oldest prediction
    task automatic check_result();
        bmmg_pkg::res_t want;
        if (translations_due.size() == 0)
        begin
            report_mismatch("unrequested word", m_tdata, 0);
            return;
        end
        want = translations_due.pop_front();
        if (m_tdata[22:0] !== want.phys_addr)
            report_mismatch("phys_addr", m_tdata[22:0], want.phys_addr);
        if (m_tuser !== want.target)
            report_mismatch("target", m_tuser, want.target);
        if (m_tdata[30:23] !== want.data_out)
            report_mismatch("data_out", m_tdata[30:23], want.data_out);
        if (m_tdata[38:31] !== want.wait_cycles)
            report_mismatch("wait_cycles", m_tdata[38:31], want.wait_cycles);
        if (m_tdata[39] !== want.flash_exec_fault)
            report_mismatch("flash_exec_fault", m_tdata[39], want.flash_exec_fault);
        if (m_tdata[40] !== want.ram_exec_fault)
            report_mismatch("ram_exec_fault", m_tdata[40], want.ram_exec_fault);
        if (m_tdata[41] !== want.no_os_fault)
            report_mismatch("no_os_fault", m_tdata[41], want.no_os_fault);
        if (m_tdata[44:42] !== want.protect_level)
            report_mismatch("protect_level", m_tdata[44:42], want.protect_level);
    endtask

    // Sender: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                translations_due.push_back(translate_access(on_bus));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0 || accesses_to_send.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    on_bus = accesses_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= on_bus.func;
                    s_tdata <= {on_bus.wr_byte, on_bus.mem_byte, on_bus.addr};
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
                    end
                end
            end
        end
    end

    // Receiver: own stall pattern, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (holds_served != hold_asks)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            stall_tick++;
            case (pace)
                PACE_FULL:  m_tready <= 1'b1;
                PACE_COIN:  m_tready <= 1'($urandom_range(0, 1));
                PACE_CYCLE: m_tready <= (stall_tick % 7) < 4;
                default:    m_tready <= $urandom_range(0, 7) != 0;
            endcase
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
    end

    // Register write: setup cycle then access cycle
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            bmmg_pkg::REG_BANK_PAGES:   mapper_cfg.bank_pages = value[35:0];
            bmmg_pkg::REG_TOP_WIN:      mapper_cfg.top_window_size = value[7:0];
            bmmg_pkg::REG_BOTTOM_WIN:   mapper_cfg.bottom_window_size = value[7:0];
            bmmg_pkg::REG_FLASH_BOUNDS: mapper_cfg.flash_exec_bounds = value[17:0];
            bmmg_pkg::REG_RAM_MASK:     mapper_cfg.ram_exec_mask = value[22:0];
            bmmg_pkg::REG_RAM_BOUNDS:   mapper_cfg.ram_exec_bounds = value[45:0];
            bmmg_pkg::REG_WAIT_STATES:  mapper_cfg.wait_states = value[47:0];
            default:                    mapper_cfg.flash_unlocked = value[0];
        endcase
    endtask

    task automatic write_all(logic [35:0] banks, logic [7:0] top, logic [7:0] bottom,
                             logic [17:0] fbounds, logic [22:0] rmask, logic [45:0] rbounds,
                             logic [47:0] waits, logic unlocked);
        write_reg(bmmg_pkg::REG_BANK_PAGES, 64'(banks));
        write_reg(bmmg_pkg::REG_TOP_WIN, 64'(top));
        write_reg(bmmg_pkg::REG_BOTTOM_WIN, 64'(bottom));
        write_reg(bmmg_pkg::REG_FLASH_BOUNDS, 64'(fbounds));
        write_reg(bmmg_pkg::REG_RAM_MASK, 64'(rmask));
        write_reg(bmmg_pkg::REG_RAM_BOUNDS, 64'(rbounds));
        write_reg(bmmg_pkg::REG_WAIT_STATES, 64'(waits));
        write_reg(bmmg_pkg::REG_UNLOCKED, 64'(unlocked));
        @(negedge clk);
    endtask

    task automatic load_random_config(bit force_seq);
        logic [3:0][8:0] banks;
        logic [8:0]      lo9;
        logic [8:0]      hi9;
        logic [22:0]     lo23;
        logic [22:0]     hi23;
        logic [22:0]     rmask;
        logic [7:0]      top;
        logic [7:0]      bottom;
        int              pick;
        banks = 36'({$urandom, $urandom});
        if (force_seq)
        begin
            pick = $urandom_range(0, 7);
            banks[$urandom_range(0, 3)] = (pick < 4) ? 9'(9'h0EC + pick) : 9'(9'h0FC + pick - 4);
        end
        lo9 = 9'($urandom);
        hi9 = 9'($urandom);
        if (lo9 > hi9 && $urandom_range(0, 2) != 0)
            {lo9, hi9} = {hi9, lo9};
        lo23 = 23'($urandom);
        hi23 = 23'($urandom);
        if (lo23 > hi23 && $urandom_range(0, 2) != 0)
            {lo23, hi23} = {hi23, lo23};
        rmask = ($urandom_range(0, 1) != 0) ? 23'h7FFFFF : 23'($urandom);
        top = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
        bottom = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
        write_all(banks, top, bottom, {hi9, lo9}, rmask, {hi23, lo23},
                  48'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
    endtask

    function automatic void queue_access(bmmg_pkg::func_t f, logic [15:0] a, logic [7:0] m,
                                         logic [7:0] w);
        accesses_to_send.push_back(access_t'{f, a, m, w});
    endfunction

    // Logical address that lands in the unlock window, if one is found
    function automatic logic [15:0] seq_addr();
        logic [15:0] a;
        a = 16'($urandom);
        for (int k = 0; k < 64; k++)
        begin
            a = 16'($urandom);
            if (in_unlock_window({page_of(a), a[13:0]}))
                return a;
        end
        return a;
    endfunction

    // Address biased toward bank edges, window edges and the OS entry
    function automatic logic [15:0] pick_addr();
        case ($urandom_range(0, 9))
            0:       return bmmg_pkg::LA_OS_ENTRY;
            1:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            2:       return 16'(32'h10000 - 64 * int'(mapper_cfg.top_window_size));
            3:       return 16'(32'h8000 + 64 * int'(mapper_cfg.bottom_window_size) - 1);
            4:       return {2'($urandom), ($urandom_range(0, 1) != 0) ? 14'h3FFF : 14'h0000};
            default: return 16'($urandom);
        endcase
    endfunction

    // Random mix: unlock sequences with random content, broken runs and noise
    task automatic queue_mix(int count);
        int              made;
        int              run;
        logic [15:0]     a;
        logic [7:0]      b;
        bmmg_pkg::func_t f;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 9) < 4)
            begin
                a = seq_addr();
                // two off-key reads bring the tracker back to zero unless the page is blocked
                queue_access(bmmg_pkg::FUNC_READ, a, 8'h01, 8'($urandom));
                queue_access(bmmg_pkg::FUNC_READ, a, 8'h01, 8'($urandom));
                run = $urandom_range(2, 8);
                for (int k = 0; k < run; k++)
                begin
                    if (k < 6)
                        b = unlock_key[k];
                    else
                        b = 8'($urandom);
                    if ($urandom_range(0, 15) == 0)
                        b = 8'($urandom);
                    f = ($urandom_range(0, 3) == 0) ? bmmg_pkg::FUNC_FETCH : bmmg_pkg::FUNC_READ;
                    if ($urandom_range(0, 7) == 0)
                    begin
                        queue_access(($urandom_range(0, 1) != 0) ? bmmg_pkg::FUNC_WRITE
                                                                 : bmmg_pkg::FUNC_XLATE,
                                     16'($urandom), 8'($urandom), 8'($urandom));
                        made++;
                    end
                    queue_access(f, a + 16'(k), b, 8'($urandom));
                end
                made += run + 2;
            end
            else
            begin
                f = bmmg_pkg::func_t'($urandom_range(0, 3));
                b = ($urandom_range(0, 3) == 0) ? bmmg_pkg::BYTE_ERASED : 8'($urandom);
                queue_access(f, pick_addr(), b, 8'($urandom));
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        while (accesses_to_send.size() != 0 || s_tvalid || translations_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_pacing(pace_t p, int gmax);
        pace = p;
        gap_max = gmax;
    endtask

    // Directed words: key walk, blocked page, OS check, windows, faults
    task automatic queue_directed();
        queue_access(bmmg_pkg::FUNC_READ, 16'h0000, 8'h00, 8'h00);
        queue_access(bmmg_pkg::FUNC_READ, 16'h9000, 8'h00, 8'h00);
        queue_access(bmmg_pkg::FUNC_WRITE, 16'h9001, 8'h00, 8'hFF);
        queue_access(bmmg_pkg::FUNC_READ, 16'h9002, 8'h00, 8'h00);
        queue_access(bmmg_pkg::FUNC_XLATE, 16'h9003, 8'hFF, 8'hFF);
        queue_access(bmmg_pkg::FUNC_READ, 16'h9004, 8'hED, 8'h00);
        queue_access(bmmg_pkg::FUNC_READ, 16'h9005, 8'h56, 8'h00);
        queue_access(bmmg_pkg::FUNC_FETCH, 16'h9006, 8'hF3, 8'h00);
        queue_access(bmmg_pkg::FUNC_READ, 16'h9007, 8'hD3, 8'h00);
        queue_access(bmmg_pkg::FUNC_READ, 16'h9008, 8'h5A, 8'h00);
        queue_access(bmmg_pkg::FUNC_READ, 16'h0000, 8'h00, 8'h00);
        queue_access(bmmg_pkg::FUNC_READ, 16'h4000, 8'h12, 8'h00);
        queue_access(bmmg_pkg::FUNC_FETCH, 16'h7FFF, 8'h34, 8'h00);
        queue_access(bmmg_pkg::FUNC_WRITE, 16'h4000, 8'hFF, 8'h00);
        queue_access(bmmg_pkg::FUNC_FETCH, bmmg_pkg::LA_OS_ENTRY, 8'hFF, 8'h00);
        queue_access(bmmg_pkg::FUNC_FETCH, bmmg_pkg::LA_OS_ENTRY, 8'h00, 8'hFF);
        queue_access(bmmg_pkg::FUNC_FETCH, 16'hFFFF, 8'hA5, 8'h00);
        queue_access(bmmg_pkg::FUNC_READ, 16'h8000, 8'hFF, 8'h00);
        queue_access(bmmg_pkg::FUNC_READ, 16'h80FF, 8'h00, 8'h00);
        queue_access(bmmg_pkg::FUNC_READ, 16'h8100, 8'h00, 8'h00);
        queue_access(bmmg_pkg::FUNC_WRITE, 16'hC000, 8'h00, 8'hFF);
        queue_access(bmmg_pkg::FUNC_FETCH, 16'hC123, 8'h3C, 8'h00);
        queue_access(bmmg_pkg::FUNC_READ, 16'hFEFF, 8'hC3, 8'h00);
        queue_access(bmmg_pkg::FUNC_XLATE, 16'hFF00, 8'h00, 8'h00);
        queue_access(bmmg_pkg::FUNC_XLATE, 16'h3FFF, 8'hFF, 8'hFF);
    endtask

    // Stimulus phases, registers rewritten only while idle
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    // banks: 0x000, protected 0x0FE, key window 0x0EC, far RAM 0x1FF
                    write_all({9'h1FF, 9'h0EC, 9'h0FE, 9'h000}, 8'd4, 8'd4,
                              {9'h0EC, 9'h0EC}, 23'h7FFFFF, {23'h40FFFF, 23'h400000},
                              48'h060504030201, 1'b0);
                    set_pacing(PACE_FULL, 0);
                    queue_directed();
                end
                1:
                begin
                    write_reg(bmmg_pkg::REG_UNLOCKED, 64'd1);
                    @(negedge clk);
                    set_pacing(PACE_COIN, 3);
                    queue_access(bmmg_pkg::FUNC_READ, 16'h4000, 8'h77, 8'h00);
                    queue_mix(150);
                end
                2:
                begin
                    write_all('0, '0, '0, '0, '0, '0, '0, 1'b0);
                    set_pacing(PACE_CYCLE, 6);
                    queue_mix(120);
                end
                3:
                begin
                    write_all('1, '1, '1, '1, '1, '1, '1, 1'b1);
                    set_pacing(PACE_COIN, 0);
                    queue_mix(120);
                end
                4:
                begin
                    load_random_config(1'b1);
                    set_pacing(PACE_RARE, 2);
                    queue_mix(200);
                    // receiver holds off while the sender keeps offering
                    repeat (20) @(negedge clk);
                    hold_asks++;
                end
                5:
                begin
                    load_random_config(1'b1);
                    set_pacing(PACE_COIN, 4);
                    queue_mix(200);
                end
                6:
                begin
                    load_random_config(1'b0);
                    set_pacing(PACE_CYCLE, 1);
                    queue_mix(150);
                end
                default:
                begin
                    load_random_config(1'b1);
                    set_pacing(PACE_FULL, 3);
                    queue_mix(150);
                    hold_asks++;
                end
            endcase
        end
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule
